### src/vehicle_pose_integrator_unit_defines.svh
// Assertion macros shared by the pose integrator RTL.
`ifndef VEHICLE_POSE_INTEGRATOR_UNIT_DEFINES_SVH
`define VEHICLE_POSE_INTEGRATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define VPI_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define VPI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/vpi_pkg.sv
// Shared constants, types and tables of the pose integrator.
package vpi_pkg;

  localparam int CORDIC_STEPS = 14;
  localparam int AtanLen      = 24;
  localparam int CordicIters  = (CORDIC_STEPS < AtanLen) ? CORDIC_STEPS : AtanLen;
  localparam int IterW        = 5;

  localparam int CsW  = 34;
  localparam int AccW = 2 * CsW;

  localparam int PiQ     = 25736;
  localparam int TwoPiQ  = 51472;
  localparam int HalfPiQ = 12868;

  localparam logic signed [CsW-1:0] CordicGain = 34'sd652032874;
  // ceil(2^32 / 25), exact floor division for values below 2^29
  localparam logic signed [CsW-1:0] Recip25    = 34'sd171798692;
  // floor(x / 100) = (x * 41944) >> 22 for x below 2^15 + 100
  localparam logic [15:0]           Recip100   = 16'd41944;
  localparam logic [AccW-1:0]       HalfDen    = 68'd13421772800;
  localparam logic signed [AccW-1:0] RndHalf   = 68'sd536870912;

  localparam logic [2:0] CfgOffsetX      = 3'd0;
  localparam logic [2:0] CfgOffsetY      = 3'd1;
  localparam logic [2:0] CfgBodyHeight   = 3'd2;
  localparam logic [2:0] CfgStartX       = 3'd3;
  localparam logic [2:0] CfgStartY       = 3'd4;
  localparam logic [2:0] CfgStartHeading = 3'd5;

  typedef enum logic [1:0] {MacLoad, MacLoadNeg, MacAdd, MacSub} mac_mode_e;
  typedef enum logic [1:0] {Sh0, Sh5, Sh15} mac_shift_e;

  typedef struct packed {
    logic       valid;
    mac_mode_e  mode;
    mac_shift_e shift;
  } mac_ctl_t;

  function automatic logic [31:0] atan_entry(input logic [IterW-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h3243F6A8;
      5'd1:    v = 32'h1DAC6705;
      5'd2:    v = 32'h0FADBAFC;
      5'd3:    v = 32'h07F56EA6;
      5'd4:    v = 32'h03FEAB76;
      5'd5:    v = 32'h01FFD55B;
      5'd6:    v = 32'h00FFFAAA;
      5'd7:    v = 32'h007FFF55;
      5'd8:    v = 32'h003FFFEA;
      5'd9:    v = 32'h001FFFFD;
      5'd10:   v = 32'h000FFFFF;
      5'd11:   v = 32'h0007FFFF;
      5'd12:   v = 32'h0003FFFF;
      5'd13:   v = 32'h0001FFFF;
      5'd14:   v = 32'h0000FFFF;
      5'd15:   v = 32'h00007FFF;
      5'd16:   v = 32'h00003FFF;
      5'd17:   v = 32'h00001FFF;
      5'd18:   v = 32'h00000FFF;
      5'd19:   v = 32'h000007FF;
      5'd20:   v = 32'h000003FF;
      5'd21:   v = 32'h000001FF;
      5'd22:   v = 32'h000000FF;
      5'd23:   v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

### src/vpi_if.sv
// Handshake channel interfaces of the pose integrator.
interface vpi_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [15:0] speed;
  logic signed [15:0] turn_rate;
  logic signed [15:0] ground_roll;
  logic signed [15:0] ground_pitch;
  logic signed [31:0] ground_height;
  modport source (output valid, action, speed, turn_rate, ground_roll, ground_pitch,
                  ground_height, input ready);
  modport sink (input valid, action, speed, turn_rate, ground_roll, ground_pitch,
                ground_height, output ready);
endinterface

interface vpi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] roll_out;
  logic signed [15:0] pitch_out;
  logic signed [15:0] heading_out;
  logic signed [23:0] roll_speed;
  logic signed [23:0] pitch_speed;
  logic signed [31:0] climb_speed;
  modport source (output valid, pos_x, pos_y, pos_z, roll_out, pitch_out, heading_out,
                  roll_speed, pitch_speed, climb_speed, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, roll_out, pitch_out, heading_out,
                roll_speed, pitch_speed, climb_speed, output ready);
endinterface

interface vpi_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/vpi_cordic.sv
// Iterative rotation-mode CORDIC: Q3.13 angle to Q.30 cosine and sine.
`include "vehicle_pose_integrator_unit_defines.svh"
module vpi_cordic (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [15:0]              angle_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic signed [vpi_pkg::CsW-1:0]  cos_o,
  output logic signed [vpi_pkg::CsW-1:0]  sin_o
);
  import vpi_pkg::*;

  logic                  busy_q, done_q, neg_q;
  logic [IterW-1:0]      iter_q;
  logic signed [CsW-1:0] x_q, y_q, z_q, x_d, y_d, z_d;
  logic signed [CsW-1:0] cos_q, sin_q;
  logic signed [16:0]    ang, red;
  logic                  red_neg, last;
  logic signed [CsW-1:0] xs, ys, at;

  // Fold angles beyond a quarter turn by pi.
  always_comb begin
    ang     = 17'(angle_i);
    red     = ang;
    red_neg = 1'b0;
    if (ang > 17'sd12868) begin
      red     = ang - 17'(PiQ);
      red_neg = 1'b1;
    end else if (ang < -17'sd12868) begin
      red     = ang + 17'(PiQ);
      red_neg = 1'b1;
    end
  end

  always_comb begin
    xs = x_q >>> iter_q;
    ys = y_q >>> iter_q;
    at = signed'({2'b00, atan_entry(iter_q)});
    if (!z_q[CsW-1]) begin
      x_d = x_q - ys;
      y_d = y_q + xs;
      z_d = z_q - at;
    end else begin
      x_d = x_q + ys;
      y_d = y_q - xs;
      z_d = z_q + at;
    end
  end

  assign last = (iter_q == IterW'(CordicIters - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        iter_q <= iter_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= CordicGain;
      y_q   <= '0;
      z_q   <= {{(CsW-17){red[16]}}, red} <<< 17;
      neg_q <= red_neg;
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
      if (last) begin
        cos_q <= neg_q ? -x_d : x_d;
        sin_q <= neg_q ? -y_d : y_d;
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign cos_o  = cos_q;
  assign sin_o  = sin_q;

  `VPI_ASSERT_IMPLIES(a_start_idle, start_i, !busy_q, "cordic started while busy")
  `VPI_ASSERT_IMPLIES(a_iter_bound, busy_q, iter_q < IterW'(CordicIters), "iteration overrun")
  `VPI_ASSERT_NEXT(a_done_pulse, done_q, !done_q, "done held longer than one cycle")

endmodule

### src/vpi_mac.sv
// Shared multiply-accumulate unit: registered product, then shifted accumulate.
module vpi_mac (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  vpi_pkg::mac_ctl_t                ctl_i,
  input  logic signed [vpi_pkg::CsW-1:0]   a_i,
  input  logic signed [vpi_pkg::CsW-1:0]   b_i,
  output logic signed [vpi_pkg::AccW-1:0]  acc_o
);
  import vpi_pkg::*;

  mac_ctl_t               ctl_q;
  logic signed [AccW-1:0] prod_q, shifted, acc_q, acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      prod_q <= a_i * b_i;
    end
    acc_q <= acc_d;
  end

  always_comb begin
    case (ctl_q.shift)
      Sh5:     shifted = prod_q <<< 5;
      Sh15:    shifted = prod_q <<< 15;
      default: shifted = prod_q;
    endcase
    acc_d = acc_q;
    if (ctl_q.valid) begin
      case (ctl_q.mode)
        MacLoad:    acc_d = shifted;
        MacLoadNeg: acc_d = -shifted;
        MacAdd:     acc_d = acc_q + shifted;
        MacSub:     acc_d = acc_q - shifted;
        default:    acc_d = acc_q;
      endcase
    end
  end

  assign acc_o = acc_q;

endmodule

### src/vehicle_pose_integrator_unit.sv
// Top level of the dead-reckoning pose integrator.
//
//  channel | dir | payload                                          | transaction when
//  cfg_i   | in  | index (3), data (32)                             | valid & ready
//  in_i    | in  | action, speed, turn_rate, ground_roll/pitch/height | valid & ready
//  out_o   | out | pose, heading, roll/pitch/climb speeds           | valid & ready
//
// A tick runs from one input transaction to the next: two CORDIC runs,
// fourteen multiply-accumulate ops, each issued, multiplied and accumulated in turn
// on the one shared 34x34 multiplier, the finish step and the return to idle. The
// result is loaded at the finish step. A load action goes from idle to the finish step.
// Reset clears the pose and the sequencer and returns the configuration registers
// to their reset values.
// The result sits in an output register; the next input transaction is taken
// while it waits, and the block stalls at the finish step only if the old
// result has still not been taken.
`include "vehicle_pose_integrator_unit_defines.svh"
module vehicle_pose_integrator_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  vpi_cfg_if.sink   cfg_i,
  vpi_in_if.sink    in_i,
  vpi_out_if.source out_o
);
  import vpi_pkg::*;

  // Sequencer states
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCordA = 3'd1;
  localparam logic [2:0] StMac   = 3'd2;
  localparam logic [2:0] StCordB = 3'd3;
  localparam logic [2:0] StFin   = 3'd4;

  localparam logic [3:0] LastPc  = 4'd13;
  localparam logic [1:0] PhIssue = 2'd0;
  localparam logic [1:0] PhPost  = 2'd2;

  localparam logic signed [17:0] PiW    = 18'(PiQ);
  localparam logic signed [17:0] TwoPiW = 18'(TwoPiQ);

  function automatic logic signed [15:0] sat16(input logic signed [AccW-1:0] v);
    if (v > 68'sd32767) return 16'sh7FFF;
    if (v < -68'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
    if (v > 26'sd8388607) return 24'sh7FFFFF;
    if (v < -26'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    if (v > 42'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -42'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Configuration registers
  logic signed [23:0] off_x_q, off_y_q, body_h_q;
  logic signed [31:0] start_x_q, start_y_q;
  logic signed [15:0] start_hdg_q;

  // Pose state
  logic signed [31:0] cur_x_q, cur_y_q, cur_z_q;
  logic signed [15:0] cur_hdg_q, cur_roll_q, cur_pitch_q;

  // Sequencer
  logic [2:0] state_q;
  logic [3:0] pc_q;
  logic [1:0] ph_q;

  // Item and working registers
  logic               action_q;
  logic signed [15:0] spd_q, rate_q, troll_q, tpitch_q, h_q;
  logic signed [31:0] gh_q;
  logic signed [15:0] nr_q, np_q;
  logic signed [CsW-1:0] lever_q, t_q;
  logic               neg_q;
  logic signed [31:0] new_x_q, new_y_q;

  // Output register
  logic               out_valid_q;
  logic signed [31:0] o_x_q, o_y_q, o_z_q, o_dz_q;
  logic signed [15:0] o_roll_q, o_pitch_q, o_hdg_q;
  logic signed [23:0] o_droll_q, o_dpitch_q;

  // Shared units
  logic                  cord_start, cord_busy, cord_done;
  logic signed [15:0]    cord_angle;
  logic signed [CsW-1:0] cos_w, sin_w;
  mac_ctl_t              mac_ctl;
  logic signed [CsW-1:0] mac_a, mac_b;
  logic signed [AccW-1:0] acc;

  logic in_fire, out_fire, fin_go;

  assign in_i.ready  = (state_q == StIdle);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_fire    = out_valid_q && out_o.ready;
  assign fin_go      = (state_q == StFin) && (!out_valid_q || out_o.ready);
  assign cfg_i.ready = 1'b1;

  // Heading step: turn_rate / 100, rounded with ties away from zero, then one wrap
  logic signed [16:0] rate_ext;
  logic [16:0]        rate_mag;
  logic [32:0]        step_prod;
  logic signed [17:0] step, h_sum, h_wrap;

  always_comb begin
    rate_ext  = 17'(in_i.turn_rate);
    rate_mag  = rate_ext[16] ? 17'(-rate_ext) : 17'(rate_ext);
    step_prod = 33'(rate_mag + 17'd50) * 33'(Recip100);
    step      = rate_ext[16] ? -18'(step_prod[30:22]) : 18'(step_prod[30:22]);
    h_sum     = 18'(cur_hdg_q) + step;
    h_wrap    = h_sum;
    if (h_sum > PiW) begin
      h_wrap = h_sum - TwoPiW;
    end else if (h_sum < -PiW) begin
      h_wrap = h_sum + TwoPiW;
    end
  end

  // Start the CORDIC on the old heading at accept, on the new heading after pitch
  assign cord_start = (in_fire && !in_i.action) ||
                      (state_q == StMac && ph_q == PhPost && pc_q == 4'd3);
  assign cord_angle = (state_q == StIdle) ? cur_hdg_q : h_q;

  vpi_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .angle_i (cord_angle),
    .busy_o  (cord_busy),
    .done_o  (cord_done),
    .cos_o   (cos_w),
    .sin_o   (sin_w)
  );

  // Multiply-accumulate program
  always_comb begin
    mac_ctl.valid = (state_q == StMac) && (ph_q == PhIssue);
    mac_ctl.mode  = MacLoad;
    mac_ctl.shift = Sh0;
    mac_a         = CsW'(troll_q);
    mac_b         = cos_w;
    case (pc_q)
      4'd0: begin
        mac_a = CsW'(troll_q);  mac_b = cos_w;
      end
      4'd1: begin
        mac_a = CsW'(tpitch_q); mac_b = sin_w; mac_ctl.mode = MacAdd;
      end
      4'd2: begin
        mac_a = CsW'(tpitch_q); mac_b = cos_w;
      end
      4'd3: begin
        mac_a = CsW'(troll_q);  mac_b = sin_w; mac_ctl.mode = MacSub;
      end
      4'd4: begin
        mac_a = CsW'(off_x_q);  mac_b = sin_w; mac_ctl.mode = MacLoadNeg;
      end
      4'd5: begin
        mac_a = CsW'(off_y_q);  mac_b = cos_w; mac_ctl.mode = MacSub;
      end
      4'd6: begin
        mac_a = CsW'(spd_q);    mac_b = cos_w; mac_ctl.shift = Sh5;
      end
      4'd7: begin
        mac_a = CsW'(rate_q);   mac_b = lever_q;
        mac_ctl.mode = MacAdd;  mac_ctl.shift = Sh15;
      end
      4'd8: begin
        mac_a = t_q;            mac_b = Recip25;
      end
      4'd9: begin
        mac_a = CsW'(off_x_q);  mac_b = cos_w;
      end
      4'd10: begin
        mac_a = CsW'(off_y_q);  mac_b = sin_w; mac_ctl.mode = MacSub;
      end
      4'd11: begin
        mac_a = CsW'(spd_q);    mac_b = sin_w; mac_ctl.shift = Sh5;
      end
      4'd12: begin
        mac_a = CsW'(rate_q);   mac_b = lever_q;
        mac_ctl.mode = MacAdd;  mac_ctl.shift = Sh15;
      end
      4'd13: begin
        mac_a = t_q;            mac_b = Recip25;
      end
      default: begin
        mac_ctl.valid = 1'b0;
      end
    endcase
  end

  vpi_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (acc)
  );

  // Post-processing of the accumulator
  logic signed [AccW-1:0] acc_rnd;
  logic [AccW-1:0]        acc_mag, t_sum;
  logic signed [41:0]     quo, pos_x_sum, pos_y_sum;

  always_comb begin
    acc_rnd   = (acc + RndHalf) >>> 30;
    acc_mag   = acc[AccW-1] ? AccW'(-acc) : AccW'(acc);
    t_sum     = (acc_mag + HalfDen) >> 30;
    quo       = 42'(acc[63:32]);
    quo       = neg_q ? -quo : quo;
    pos_x_sum = 42'(cur_x_q) + quo;
    pos_y_sum = 42'(cur_y_q) + quo;
  end

  // Finish step: z, rates and the new pose
  logic signed [41:0] z_sum, z_diff, dz_prod;
  logic signed [31:0] nz;
  logic signed [25:0] dr_diff, dp_diff, dr_prod, dp_prod;

  always_comb begin
    z_sum   = 42'(gh_q) + 42'(body_h_q);
    nz      = sat32(z_sum);
    z_diff  = 42'(nz) - 42'(cur_z_q);
    dz_prod = (z_diff <<< 7) + (z_diff <<< 6) + (z_diff <<< 3);
    dr_diff = 26'(nr_q) - 26'(cur_roll_q);
    dp_diff = 26'(np_q) - 26'(cur_pitch_q);
    dr_prod = (dr_diff <<< 7) + (dr_diff <<< 6) + (dr_diff <<< 3);
    dp_prod = (dp_diff <<< 7) + (dp_diff <<< 6) + (dp_diff <<< 3);
  end

  // Control and pose state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pc_q        <= '0;
      ph_q        <= '0;
      out_valid_q <= 1'b0;
      off_x_q     <= '0;
      off_y_q     <= '0;
      body_h_q    <= 24'sd49152;
      start_x_q   <= '0;
      start_y_q   <= '0;
      start_hdg_q <= '0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      cur_z_q     <= '0;
      cur_hdg_q   <= '0;
      cur_roll_q  <= '0;
      cur_pitch_q <= '0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CfgOffsetX:      off_x_q     <= cfg_i.data[23:0];
          CfgOffsetY:      off_y_q     <= cfg_i.data[23:0];
          CfgBodyHeight:   body_h_q    <= cfg_i.data[23:0];
          CfgStartX:       start_x_q   <= cfg_i.data;
          CfgStartY:       start_y_q   <= cfg_i.data;
          CfgStartHeading: start_hdg_q <= cfg_i.data[15:0];
          default: ;
        endcase
      end

      // Drop the result once taken, unless the finish step reloads it now.
      if (out_fire && !fin_go) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (in_fire) begin
            state_q <= in_i.action ? StFin : StCordA;
          end
        end
        StCordA: begin
          if (cord_done) begin
            state_q <= StMac;
            pc_q    <= '0;
            ph_q    <= PhIssue;
          end
        end
        StMac: begin
          if (ph_q == PhPost) begin
            ph_q <= PhIssue;
            pc_q <= pc_q + 1'b1;
            if (pc_q == 4'd3) begin
              state_q <= StCordB;
            end else if (pc_q == LastPc) begin
              state_q <= StFin;
            end
          end else begin
            ph_q <= ph_q + 1'b1;
          end
        end
        StCordB: begin
          if (cord_done) begin
            state_q <= StMac;
          end
        end
        StFin: begin
          if (fin_go) begin
            // Commit the new pose and load the output register.
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
            if (action_q) begin
              cur_x_q   <= start_x_q;
              cur_y_q   <= start_y_q;
              cur_hdg_q <= start_hdg_q;
            end else begin
              cur_x_q     <= new_x_q;
              cur_y_q     <= new_y_q;
              cur_z_q     <= nz;
              cur_hdg_q   <= h_q;
              cur_roll_q  <= nr_q;
              cur_pitch_q <= np_q;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      action_q <= in_i.action;
      spd_q    <= in_i.speed;
      rate_q   <= in_i.turn_rate;
      troll_q  <= in_i.ground_roll;
      tpitch_q <= in_i.ground_pitch;
      gh_q     <= in_i.ground_height;
      h_q      <= h_wrap[15:0];
    end

    if (state_q == StMac && ph_q == PhPost) begin
      case (pc_q)
        4'd1:         nr_q    <= sat16(acc_rnd);
        4'd3:         np_q    <= sat16(acc_rnd);
        4'd5, 4'd10:  lever_q <= acc_rnd[CsW-1:0];
        4'd7, 4'd12: begin
          neg_q <= acc[AccW-1];
          t_q   <= signed'(t_sum[CsW-1:0]);
        end
        4'd8:         new_x_q <= sat32(pos_x_sum);
        4'd13:        new_y_q <= sat32(pos_y_sum);
        default: ;
      endcase
    end

    if (fin_go) begin
      if (action_q) begin
        o_x_q      <= start_x_q;
        o_y_q      <= start_y_q;
        o_z_q      <= cur_z_q;
        o_hdg_q    <= start_hdg_q;
        o_roll_q   <= cur_roll_q;
        o_pitch_q  <= cur_pitch_q;
        o_droll_q  <= '0;
        o_dpitch_q <= '0;
        o_dz_q     <= '0;
      end else begin
        o_x_q      <= new_x_q;
        o_y_q      <= new_y_q;
        o_z_q      <= nz;
        o_hdg_q    <= h_q;
        o_roll_q   <= nr_q;
        o_pitch_q  <= np_q;
        o_droll_q  <= sat24(dr_prod);
        o_dpitch_q <= sat24(dp_prod);
        o_dz_q     <= sat32(dz_prod);
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pos_x       = o_x_q;
  assign out_o.pos_y       = o_y_q;
  assign out_o.pos_z       = o_z_q;
  assign out_o.roll_out    = o_roll_q;
  assign out_o.pitch_out   = o_pitch_q;
  assign out_o.heading_out = o_hdg_q;
  assign out_o.roll_speed  = o_droll_q;
  assign out_o.pitch_speed = o_dpitch_q;
  assign out_o.climb_speed = o_dz_q;

  `VPI_ASSERT_IMPLIES(a_mac_cordic_excl, mac_ctl.valid, !cord_busy, "mac issued during cordic")
  `VPI_ASSERT_IMPLIES(a_pc_range, state_q == StMac, pc_q <= LastPc, "program counter overrun")
  `VPI_ASSERT_NEXT(a_fin_loads_out, fin_go, out_valid_q && state_q == StIdle, "finish lost result")

endmodule
